>>> rtl/core/hct_pkg.sv
// Shared types, codes and rate limits for the handheld console timer.
package hct_pkg;

  // Input clock of the console; must be a power of two so each limit is one.
  localparam int unsigned CLOCK_HZ = 4194304;

  // Clocks per machine cycle.
  localparam int unsigned MCYCLE_CLOCKS = 4;

  // Clock counts per counter increment, one for each rate code.
  localparam int unsigned RATE0_DIV = CLOCK_HZ / 4096;
  localparam int unsigned RATE1_DIV = CLOCK_HZ / 262144;
  localparam int unsigned RATE2_DIV = CLOCK_HZ / 65536;
  localparam int unsigned RATE3_DIV = CLOCK_HZ / 16384;

  localparam logic [31:0] RATE0_LIMIT = (RATE0_DIV == 0) ? 32'd1 : 32'(RATE0_DIV);
  localparam logic [31:0] RATE1_LIMIT = (RATE1_DIV == 0) ? 32'd1 : 32'(RATE1_DIV);
  localparam logic [31:0] RATE2_LIMIT = (RATE2_DIV == 0) ? 32'd1 : 32'(RATE2_DIV);
  localparam logic [31:0] RATE3_LIMIT = (RATE3_DIV == 0) ? 32'd1 : 32'(RATE3_DIV);

  // Bit positions in the control register.
  localparam int unsigned CTRL_ENABLE_BIT = 2;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  // Register selects.
  typedef enum logic [1:0] {
    REG_DIVIDER = 2'd0,
    REG_COUNTER = 2'd1,
    REG_RELOAD  = 2'd2,
    REG_CONTROL = 2'd3
  } reg_sel_t;

  // Input word.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic [5:0] cycles;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [7:0] read_data;
    logic       interrupt_request;
  } out_word_t;

  // Limit for a rate code.
  function automatic logic [31:0] rate_limit(input logic [1:0] rate);
    logic [31:0] lim;
    unique case (rate)
      2'd0:    lim = RATE0_LIMIT;
      2'd1:    lim = RATE1_LIMIT;
      2'd2:    lim = RATE2_LIMIT;
      default: lim = RATE3_LIMIT;
    endcase
    return lim;
  endfunction

endpackage

>>> rtl/core/handheld_console_timer.sv
// Top level of the handheld console timer: input register, timer state and result register.
// An accepted word is held in the input register, then its result in the result register.
// Throughput: one word per cycle unless out_ready stalls; the timer state is updated in the
// same cycle that the registered word is processed, so the next word always sees it.
// Reset (rst_n low, synchronous): all timer registers and both valid flags clear to zero.
// Backpressure on the result side stalls the input register and drops in_ready.
module handheld_console_timer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hct_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hct_pkg::out_word_t out_data
);

  // Input register.
  logic              in_valid_r;
  hct_pkg::in_word_t item_r;

  // Timer state.
  logic [7:0]  div_r,    div_nxt;
  logic [31:0] acc_r,    acc_nxt;
  logic [7:0]  timer_r,  timer_nxt;
  logic [7:0]  reload_r, reload_nxt;
  logic [2:0]  ctrl_r,   ctrl_nxt;

  // Result register.
  logic               out_valid_r;
  hct_pkg::out_word_t out_data_r, out_data_nxt;

  logic        advance;
  logic        fire;
  logic [31:0] acc_sum;
  logic [31:0] limit;
  logic        hit;

  // Handshake: the registered word moves on when the result slot is free or emptying.
  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Tick arithmetic: accumulate clocks and compare against the selected limit.
  assign acc_sum = acc_r + (32'(item_r.cycles) * 32'(hct_pkg::MCYCLE_CLOCKS));
  assign limit   = hct_pkg::rate_limit(ctrl_r[1:0]);
  assign hit     = ctrl_r[hct_pkg::CTRL_ENABLE_BIT] && (acc_sum >= limit);

  // Next state and result for the registered word.
  always_comb begin
    div_nxt      = div_r;
    acc_nxt      = acc_r;
    timer_nxt    = timer_r;
    reload_nxt   = reload_r;
    ctrl_nxt     = ctrl_r;
    out_data_nxt = '0;
    unique case (hct_pkg::kind_t'(item_r.kind))
      hct_pkg::KIND_TICK: begin
        div_nxt = div_r + {2'd0, item_r.cycles};
        acc_nxt = acc_sum;
        if (hit) begin
          // Limit is a power of two, so the remainder is a mask.
          acc_nxt = acc_sum & (limit - 32'd1);
          if (timer_r == 8'hFF) begin
            timer_nxt                      = reload_r;
            out_data_nxt.interrupt_request = 1'b1;
          end else begin
            timer_nxt = timer_r + 8'd1;
          end
        end
      end
      hct_pkg::KIND_READ: begin
        unique case (hct_pkg::reg_sel_t'(item_r.reg_select))
          hct_pkg::REG_DIVIDER: out_data_nxt.read_data = div_r;
          hct_pkg::REG_COUNTER: out_data_nxt.read_data = timer_r;
          hct_pkg::REG_RELOAD:  out_data_nxt.read_data = reload_r;
          default:              out_data_nxt.read_data = {6'd0, ctrl_r[1:0]};
        endcase
      end
      hct_pkg::KIND_WRITE: begin
        unique case (hct_pkg::reg_sel_t'(item_r.reg_select))
          hct_pkg::REG_DIVIDER: div_nxt    = 8'd0;
          hct_pkg::REG_COUNTER: timer_nxt  = item_r.write_data;
          hct_pkg::REG_RELOAD:  reload_nxt = item_r.write_data;
          default:              ctrl_nxt   = item_r.write_data[2:0];
        endcase
      end
      default: begin
        // Unused kind: nothing changes and the result is zero.
      end
    endcase
  end

  // Control and timer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      div_r       <= '0;
      acc_r       <= '0;
      timer_r     <= '0;
      reload_r    <= '0;
      ctrl_r      <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        div_r    <= div_nxt;
        acc_r    <= acc_nxt;
        timer_r  <= timer_nxt;
        reload_r <= reload_nxt;
        ctrl_r   <= ctrl_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // A stalled input word stays in place.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(item_r))
    else $error("input word lost or changed while stalled");

  // An interrupt always leaves the counter at the reload value.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && out_data_nxt.interrupt_request |=> timer_r == $past(reload_r))
    else $error("counter not reloaded on overflow");

  // Only reads produce read data.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_r.kind != hct_pkg::KIND_READ |=> out_data_r.read_data == 8'd0)
    else $error("read data on a non-read word");

  // With the timer disabled, a tick leaves the counter alone.
  assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_r.kind == hct_pkg::KIND_TICK && !ctrl_r[hct_pkg::CTRL_ENABLE_BIT]
      |=> $stable(timer_r) && !out_data_r.interrupt_request)
    else $error("disabled timer counted");

endmodule
